### rtl/core/wrbu_pkg.sv
// Package for the word ring bit unpacker: sizes, mode and register codes,
// and the packed item types of the input, output and statistics paths.
// Depends on nothing; wrbu_stats and word_ring_bit_unpacker in rtl/core use it by scoped names.
package wrbu_pkg;

	// Built ring depth and the widths that follow from it.
	localparam int DEPTH  = 64;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// Fixed field widths.
	localparam int WORD_W  = 32;
	localparam int WIU_W   = 7;
	localparam int MODE_W  = 2;
	localparam int BITS_W  = $clog2(WORD_W + 1);
	localparam int ONES_W  = $clog2(WORD_W + 1);
	localparam int CFG_IDX_W = 2;

	// Register reset values.
	localparam logic [WIU_W-1:0]  WIU_RESET    = WIU_W'(64);
	localparam logic [WORD_W-1:0] PERIOD_RESET = WORD_W'(1000);

	// Operation codes.
	localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REFILL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BIT    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_POP    = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_WORDS_IN_USE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd1;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [WORD_W-1:0] word_in;
		logic [WORD_W-1:0] now_ms;
	} in_t;

	typedef struct packed {
		logic              bits_ready;
		logic              bit_value;
		logic [WORD_W-1:0] word_out;
		logic [WIU_W-1:0]  words_held;
		logic [WIU_W-1:0]  high_water;
		logic [WORD_W-1:0] overrun_count;
		logic [WORD_W-1:0] word_underrun_count;
		logic [WORD_W-1:0] bit_underrun_count;
		logic [WORD_W-1:0] sample_words;
		logic [WORD_W-1:0] sample_ones;
		logic [WORD_W-1:0] sample_interval_ms;
	} out_t;

	// Last completed statistics window.
	typedef struct packed {
		logic [WORD_W-1:0] words;
		logic [WORD_W-1:0] ones;
		logic [WORD_W-1:0] interval_ms;
	} sample_t;

endpackage

### rtl/core/wrbu_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package dependency.
module wrbu_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered read data.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/wrbu_stats.sv
// Statistics window for the word ring bit unpacker: counts words and one bits
// loaded into the shifter and latches a sample when the window expires.
// Depends on wrbu_pkg.
module wrbu_stats (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [wrbu_pkg::WORD_W-1:0]   word,
	input  logic [wrbu_pkg::WORD_W-1:0]   now_ms,
	input  logic [wrbu_pkg::WORD_W-1:0]   period_ms,
	output wrbu_pkg::sample_t             sample
);

	// Count of one bits through a tree of five levels of pairwise sums.
	function automatic logic [wrbu_pkg::ONES_W-1:0] ones_in(
		input logic [wrbu_pkg::WORD_W-1:0] w
	);
		logic [wrbu_pkg::ONES_W-1:0] s [wrbu_pkg::WORD_W];
		for (int i = 0; i < wrbu_pkg::WORD_W; i++) begin
			s[i] = wrbu_pkg::ONES_W'(w[i]);
		end
		for (int l = 0; l < $clog2(wrbu_pkg::WORD_W); l++) begin
			for (int i = 0; i < (wrbu_pkg::WORD_W >> (l + 1)); i++) begin
				s[i] = s[2*i] + s[2*i+1];
			end
		end
		return s[0];
	endfunction

	logic                          pend_s1;
	logic [wrbu_pkg::ONES_W-1:0]   ones_s1;
	logic [wrbu_pkg::WORD_W-1:0]   now_s1;
	logic [wrbu_pkg::WORD_W-1:0]   words_q;
	logic [wrbu_pkg::WORD_W-1:0]   ones_q;
	logic [wrbu_pkg::WORD_W-1:0]   start_q;
	wrbu_pkg::sample_t             sample_q;
	logic [wrbu_pkg::WORD_W-1:0]   ones_sum;
	logic [wrbu_pkg::WORD_W-1:0]   elapsed;

	assign ones_sum = ones_q + wrbu_pkg::WORD_W'(ones_s1);
	assign elapsed  = now_s1 - start_q;
	assign sample   = sample_q;

	// First stage registers the bit count of the loaded word.
	always_ff @(posedge clk) begin
		if (load) begin
			ones_s1 <= ones_in(word);
			now_s1  <= now_ms;
		end
	end

	// Word count moves on load; the one count and the window check follow in the cycle after it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1  <= 1'b0;
			words_q  <= '0;
			ones_q   <= '0;
			start_q  <= '0;
			sample_q <= '0;
		end else begin
			pend_s1 <= load;
			if (load) begin
				words_q <= words_q + 1'b1;
			end
			if (pend_s1) begin
				if (elapsed > period_ms) begin
					sample_q.words       <= words_q;
					sample_q.ones        <= ones_sum;
					sample_q.interval_ms <= elapsed;
					start_q              <= now_s1;
					words_q              <= '0;
					ones_q               <= '0;
				end else begin
					ones_q <= ones_sum;
				end
			end
		end
	end

endmodule

### rtl/core/word_ring_bit_unpacker.sv
// Channel   Direction  Signals                                  Payload
// in        input      in_valid / in_ready                      in_data (wrbu_pkg::in_t)
// out       output     out_valid / out_ready                    out_data (wrbu_pkg::out_t)
// cfg       input      cfg_valid / cfg_ready                    cfg_index, cfg_data
//
// One transaction is in flight at a time. A push, take bit, take word or non-loading refill
// passes through the data state and the emit state; a refill that loads the shifter also
// passes through the statistics state. in_ready rises together with out_valid when the emit
// state loads the output register. The states come from the registered read of the word RAM,
// the statistics stage of a loading refill and the output register.
// Reset is asynchronous and clears all counters and indices; the RAM is not cleared.
// A stalled out channel holds one finished result; one more transaction then runs up to the
// output stage and waits there. cfg is always ready.
// Depends on wrbu_pkg, wrbu_ram and wrbu_stats.
module word_ring_bit_unpacker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  wrbu_pkg::in_t                      in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output wrbu_pkg::out_t                     out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [wrbu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wrbu_pkg::WORD_W-1:0]        cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DATA = 2'd1;
	localparam logic [1:0] ST_STAT = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	// Ring index advance, wrapping at the active capacity.
	function automatic logic [wrbu_pkg::IDX_W-1:0] advance(
		input logic [wrbu_pkg::IDX_W-1:0] idx,
		input logic [wrbu_pkg::CNT_W-1:0] cap
	);
		logic [wrbu_pkg::CNT_W-1:0] nxt;
		nxt = wrbu_pkg::CNT_W'(idx) + 1'b1;
		return (nxt >= cap) ? '0 : wrbu_pkg::IDX_W'(nxt);
	endfunction

	logic [1:0]                      state_q;
	logic [wrbu_pkg::WIU_W-1:0]      wiu_q;
	logic [wrbu_pkg::WORD_W-1:0]     period_q;
	logic [wrbu_pkg::IDX_W-1:0]      head_q;
	logic [wrbu_pkg::IDX_W-1:0]      tail_q;
	logic [wrbu_pkg::CNT_W-1:0]      occ_q;
	logic [wrbu_pkg::CNT_W-1:0]      peak_q;
	logic [wrbu_pkg::WORD_W-1:0]     overruns_q;
	logic [wrbu_pkg::WORD_W-1:0]     word_under_q;
	logic [wrbu_pkg::WORD_W-1:0]     bit_under_q;
	logic [wrbu_pkg::WORD_W-1:0]     shift_q;
	logic [wrbu_pkg::BITS_W-1:0]     bits_left_q;
	logic [wrbu_pkg::MODE_W-1:0]     mode_s1;
	logic [wrbu_pkg::WORD_W-1:0]     now_s1;
	logic                            bit_s1;
	logic                            go_s1;
	logic [wrbu_pkg::WORD_W-1:0]     word_s2;
	logic                            out_valid_q;
	wrbu_pkg::out_t                  out_q;
	logic [wrbu_pkg::CNT_W-1:0]      cap;
	logic [wrbu_pkg::CNT_W-1:0]      occ_inc;
	logic                            accept;
	logic                            refill_go;
	logic                            ram_we;
	logic                            ram_re;
	logic [wrbu_pkg::WORD_W-1:0]     ram_rdata;
	logic                            stat_load;
	logic                            emit;
	wrbu_pkg::sample_t               sample;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign occ_inc   = occ_q + 1'b1;

	// Active capacity: zero acts as one, anything past the built depth as the depth.
	always_comb begin
		if (wiu_q == '0) begin
			cap = wrbu_pkg::CNT_W'(1);
		end else if (32'(wiu_q) > 32'(wrbu_pkg::DEPTH)) begin
			cap = wrbu_pkg::CNT_W'(wrbu_pkg::DEPTH);
		end else begin
			cap = wrbu_pkg::CNT_W'(wiu_q);
		end
	end

	// RAM access is issued in the acceptance cycle.
	assign refill_go = (bits_left_q == '0) && (occ_q != '0);
	assign ram_we    = accept && (in_data.mode == wrbu_pkg::MODE_PUSH);
	assign ram_re    = accept && ((in_data.mode == wrbu_pkg::MODE_POP) ||
		((in_data.mode == wrbu_pkg::MODE_REFILL) && refill_go));
	assign stat_load = (state_q == ST_DATA) && (mode_s1 == wrbu_pkg::MODE_REFILL) && go_s1;
	assign emit      = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	wrbu_ram #(
		.DEPTH(wrbu_pkg::DEPTH),
		.WIDTH(wrbu_pkg::WORD_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(head_q),
		.wdata(in_data.word_in),
		.re   (ram_re),
		.raddr(tail_q),
		.rdata(ram_rdata)
	);

	wrbu_stats u_stats (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (stat_load),
		.word     (ram_rdata),
		.now_ms   (now_s1),
		.period_ms(period_q),
		.sample   (sample)
	);

	// Sequencer for the one transaction in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DATA;
					end
				end
				ST_DATA: begin
					state_q <= stat_load ? ST_STAT : ST_EMIT;
				end
				ST_STAT: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wiu_q    <= wrbu_pkg::WIU_RESET;
			period_q <= wrbu_pkg::PERIOD_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				wrbu_pkg::REG_WORDS_IN_USE:  wiu_q    <= cfg_data[wrbu_pkg::WIU_W-1:0];
				wrbu_pkg::REG_SAMPLE_PERIOD: period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Ring indices, occupancy, counters and the bit shifter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			occ_q        <= '0;
			peak_q       <= '0;
			overruns_q   <= '0;
			word_under_q <= '0;
			bit_under_q  <= '0;
			shift_q      <= '0;
			bits_left_q  <= '0;
			go_s1        <= 1'b0;
		end else begin
			if (accept) begin
				go_s1 <= 1'b0;
				case (in_data.mode)
					wrbu_pkg::MODE_PUSH: begin
						head_q <= advance(head_q, cap);
						if (occ_q >= cap) begin
							overruns_q <= overruns_q + 1'b1;
							occ_q      <= cap;
							tail_q     <= advance(tail_q, cap);
						end else begin
							occ_q <= occ_inc;
							if (occ_inc > peak_q) begin
								peak_q <= occ_inc;
							end
						end
					end
					wrbu_pkg::MODE_REFILL: begin
						if (refill_go) begin
							go_s1  <= 1'b1;
							tail_q <= advance(tail_q, cap);
							occ_q  <= occ_q - 1'b1;
						end
					end
					wrbu_pkg::MODE_BIT: begin
						shift_q <= {shift_q[wrbu_pkg::WORD_W-2:0], 1'b0};
						if (bits_left_q != '0) begin
							bits_left_q <= bits_left_q - 1'b1;
						end else begin
							bit_under_q <= bit_under_q + 1'b1;
						end
					end
					default: begin
						tail_q <= advance(tail_q, cap);
						if (occ_q != '0) begin
							occ_q <= occ_q - 1'b1;
							go_s1 <= 1'b1;
						end else begin
							word_under_q <= word_under_q + 1'b1;
						end
					end
				endcase
			end
			// Refill loads the shifter once the RAM data arrives.
			if (stat_load) begin
				shift_q     <= ram_rdata;
				bits_left_q <= wrbu_pkg::BITS_W'(wrbu_pkg::WORD_W);
			end
		end
	end

	// Per-transaction payload carried to the output stage.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= in_data.mode;
			now_s1  <= in_data.now_ms;
			bit_s1  <= (in_data.mode == wrbu_pkg::MODE_BIT) && shift_q[wrbu_pkg::WORD_W-1];
		end
		if (state_q == ST_DATA) begin
			word_s2 <= ((mode_s1 == wrbu_pkg::MODE_POP) && go_s1) ? ram_rdata : '0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.bits_ready          <= (bits_left_q != '0);
			out_q.bit_value           <= bit_s1;
			out_q.word_out            <= word_s2;
			out_q.words_held          <= wrbu_pkg::WIU_W'(occ_q);
			out_q.high_water          <= wrbu_pkg::WIU_W'(peak_q);
			out_q.overrun_count       <= overruns_q;
			out_q.word_underrun_count <= word_under_q;
			out_q.bit_underrun_count  <= bit_under_q;
			out_q.sample_words        <= sample.words;
			out_q.sample_ones         <= sample.ones;
			out_q.sample_interval_ms  <= sample.interval_ms;
		end
	end

endmodule

### verif/tb_word_ring_bit_unpacker.sv
// Testbench for word_ring_bit_unpacker: directed and random transactions run against
// a cycle-free predictor of the word ring, the bit shifter and the window statistics.
// Depends on wrbu_pkg and the word_ring_bit_unpacker RTL; it reads no files.
module tb_word_ring_bit_unpacker;
	timeunit 1ns;
	timeprecision 1ps;

	import wrbu_pkg::*;

	// Register indexes that map to no register; writes to them must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	// Extra wait after a drain, longest idle burst and cap on printed mismatch lines.
	localparam int RESULT_LATENCY = 4;
	localparam int STALL_MAX      = 11;
	localparam int REPORT_MAX     = 200;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_t                  in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_t                 out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;

	// Predictor state: register settings, ring, shifter and statistics window.
	logic [WIU_W-1:0]  cap_setting;
	logic [WORD_W-1:0] period_setting;
	logic [WORD_W-1:0] ring_words [DEPTH];
	int unsigned       ring_head;
	int unsigned       ring_tail;
	int unsigned       ring_count;
	int unsigned       ring_peak;
	logic [WORD_W-1:0] overrun_tally;
	logic [WORD_W-1:0] word_short_tally;
	logic [WORD_W-1:0] bit_short_tally;
	logic [WORD_W-1:0] shifter;
	int unsigned       shifter_bits;
	logic [WORD_W-1:0] win_words;
	logic [WORD_W-1:0] win_ones;
	logic [WORD_W-1:0] win_start;
	sample_t           last_window;

	// Status words still owed by the block, oldest first.
	out_t              pending_status [$];

	int unsigned       fail_count;
	int unsigned       items_sent;
	bit                idle_on;
	logic [WORD_W-1:0] clock_ms;

	word_ring_bit_unpacker u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Predictor reset: both registers at their reset values, everything else cleared.
	task automatic model_reset();
		cap_setting      = WIU_RESET;
		period_setting   = PERIOD_RESET;
		ring_head        = 0;
		ring_tail        = 0;
		ring_count       = 0;
		ring_peak        = 0;
		overrun_tally    = '0;
		word_short_tally = '0;
		bit_short_tally  = '0;
		shifter          = '0;
		shifter_bits     = 0;
		win_words        = '0;
		win_ones         = '0;
		win_start        = '0;
		last_window      = '0;
	endtask

	// Effective capacity: zero acts as one, anything above the built depth as the depth.
	function automatic int unsigned ring_capacity();
		int unsigned c;
		c = 32'(cap_setting);
		if (c < 1) c = 1;
		if (c > DEPTH) c = DEPTH;
		return c;
	endfunction

	// An index wraps to zero once it reaches the capacity in force now.
	function automatic int unsigned ring_next(input int unsigned idx);
		int unsigned n;
		n = idx + 1;
		if (n >= ring_capacity() || n >= DEPTH) n = 0;
		return n;
	endfunction

	// A pop always moves the tail; from an empty ring it counts an underrun and gives zero.
	function automatic logic [WORD_W-1:0] ring_pop();
		logic [WORD_W-1:0] w;
		w = ring_words[ring_tail];
		ring_tail = ring_next(ring_tail);
		if (ring_count > 0) begin
			ring_count--;
			return w;
		end
		word_short_tally++;
		return '0;
	endfunction

	// Applies one accepted transaction to the predictor and returns the status it causes.
	function automatic out_t unpack_step(input in_t item);
		out_t              r;
		logic [WORD_W-1:0] w;
		logic [WORD_W-1:0] span;
		r = '0;
		case (item.mode)
			MODE_PUSH: begin
				ring_words[ring_head] = item.word_in;
				ring_head = ring_next(ring_head);
				if (ring_count >= ring_capacity()) begin
					overrun_tally++;
					ring_count = ring_capacity();
					ring_tail = ring_next(ring_tail);
				end else begin
					ring_count++;
					if (ring_count > ring_peak) ring_peak = ring_count;
				end
			end
			MODE_REFILL: begin
				if (shifter_bits == 0 && ring_count != 0) begin
					w = ring_pop();
					shifter = w;
					shifter_bits = WORD_W;
					win_words++;
					win_ones += $countones(w);
					span = item.now_ms - win_start;
					// The window closes only when the elapsed time is strictly past the period.
					if (span > period_setting) begin
						last_window.words       = win_words;
						last_window.ones        = win_ones;
						last_window.interval_ms = span;
						win_start = item.now_ms;
						win_words = '0;
						win_ones  = '0;
					end
				end
			end
			MODE_BIT: begin
				r.bit_value = shifter[WORD_W-1];
				shifter = shifter << 1;
				if (shifter_bits > 0) shifter_bits--;
				else bit_short_tally++;
			end
			MODE_POP: begin
				r.word_out = ring_pop();
			end
			default: ;
		endcase
		r.bits_ready          = (shifter_bits > 0);
		r.words_held          = WIU_W'(ring_count);
		r.high_water          = WIU_W'(ring_peak);
		r.overrun_count       = overrun_tally;
		r.word_underrun_count = word_short_tally;
		r.bit_underrun_count  = bit_short_tally;
		r.sample_words        = last_window.words;
		r.sample_ones         = last_window.ones;
		r.sample_interval_ms  = last_window.interval_ms;
		return r;
	endfunction

	function automatic void check_field(input string field, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		if (got !== want) begin
			if (fail_count < REPORT_MAX)
				$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			fail_count++;
		end
	endfunction

	// Every status transaction is compared field by field with the oldest expectation.
	always @(posedge clk) begin : result_check
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_status.size() == 0) begin
				if (fail_count < REPORT_MAX)
					$display("%0t: unexpected result, expected none, actual %h", $time, out_data);
				fail_count++;
			end else begin
				want = pending_status.pop_front();
				check_field("bits_ready", WORD_W'(want.bits_ready),
					WORD_W'(out_data.bits_ready));
				check_field("bit_value", WORD_W'(want.bit_value),
					WORD_W'(out_data.bit_value));
				check_field("word_out", want.word_out, out_data.word_out);
				check_field("words_held", WORD_W'(want.words_held),
					WORD_W'(out_data.words_held));
				check_field("high_water", WORD_W'(want.high_water),
					WORD_W'(out_data.high_water));
				check_field("overrun_count", want.overrun_count, out_data.overrun_count);
				check_field("word_underrun_count", want.word_underrun_count,
					out_data.word_underrun_count);
				check_field("bit_underrun_count", want.bit_underrun_count,
					out_data.bit_underrun_count);
				check_field("sample_words", want.sample_words, out_data.sample_words);
				check_field("sample_ones", want.sample_ones, out_data.sample_ones);
				check_field("sample_interval_ms", want.sample_interval_ms,
					out_data.sample_interval_ms);
			end
		end
	end

	// The result side stalls in random bursts while idling is enabled.
	initial begin
		out_ready = 1'b1;
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, STALL_MAX)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	// Sends one transaction, optionally after an idle burst, and records its expected status.
	task automatic send_item(input logic [MODE_W-1:0] mode, input logic [WORD_W-1:0] word,
			input logic [WORD_W-1:0] now);
		in_t item;
		item.mode    = mode;
		item.word_in = word;
		item.now_ms  = now;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, STALL_MAX)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_status.push_back(unpack_step(item));
		items_sent++;
	endtask

	// Holds the sender until every owed status has come back and the block is quiet.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (RESULT_LATENCY) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_WORDS_IN_USE) cap_setting = value[WIU_W-1:0];
		else if (idx == REG_SAMPLE_PERIOD) period_setting = value;
	endtask

	// Straight out of reset: bit takes from the empty shifter, refill of an empty ring.
	task automatic test_empty_shifter();
		send_item(MODE_BIT, $urandom, $urandom);
		send_item(MODE_REFILL, $urandom, $urandom);
		send_item(MODE_BIT, $urandom, $urandom);
		drain();
	endtask

	// Writes every ring entry once, then pushes into the full ring so the oldest words go.
	task automatic test_ring_fill();
		send_item(MODE_PUSH, 32'hFFFF_FFFF, $urandom);
		send_item(MODE_PUSH, 32'h0000_0000, $urandom);
		repeat (DEPTH - 2) send_item(MODE_PUSH, $urandom, $urandom);
		send_item(MODE_PUSH, 32'hAAAA_5555, $urandom);
		send_item(MODE_PUSH, $urandom, $urandom);
		drain();
	endtask

	// Window latch at the clock extremes, refill with bits left, capacity out of range
	// at both ends, capacity cut below the occupancy, and pops from an empty ring.
	task automatic test_capacity_edges();
		send_item(MODE_REFILL, $urandom, 32'hFFFF_FFFF);
		send_item(MODE_REFILL, $urandom, 32'h0000_0000);
		send_item(MODE_BIT, $urandom, $urandom);
		send_item(MODE_BIT, $urandom, $urandom);
		send_item(MODE_POP, $urandom, $urandom);
		write_reg(REG_WORDS_IN_USE, 32'hFFFF_FF80);
		send_item(MODE_PUSH, $urandom, $urandom);
		send_item(MODE_POP, $urandom, $urandom);
		send_item(MODE_POP, $urandom, $urandom);
		send_item(MODE_POP, $urandom, $urandom);
		write_reg(REG_WORDS_IN_USE, 32'h0000_007F);
		send_item(MODE_PUSH, $urandom, $urandom);
		send_item(MODE_PUSH, $urandom, $urandom);
		send_item(MODE_POP, $urandom, $urandom);
		write_reg(REG_WORDS_IN_USE, 32'h0000_0002);
		repeat (3) send_item(MODE_PUSH, $urandom, $urandom);
		repeat (3) send_item(MODE_POP, $urandom, $urandom);
		drain();
	endtask

	// Mostly whole words through the shifter with pushes and pops between them,
	// plus a share of fully random transactions.
	task automatic run_traffic(input int unsigned n_items, input bit with_idle,
			input int unsigned step_max);
		int unsigned stop_at;
		stop_at = items_sent + n_items;
		idle_on = with_idle;
		while (items_sent < stop_at) begin
			if (with_idle && $urandom_range(0, 7) == 0) idle_on = !idle_on;
			case ($urandom_range(0, 9))
				0: send_item(MODE_W'($urandom_range(0, 3)), $urandom, $urandom);
				1, 2: repeat ($urandom_range(1, 6)) send_item(MODE_PUSH, $urandom, $urandom);
				3: repeat ($urandom_range(1, 3)) send_item(MODE_POP, $urandom, $urandom);
				default: begin
					// A jump of the clock now and then also makes it wrap.
					if ($urandom_range(0, 15) == 0) clock_ms = $urandom;
					else clock_ms += $urandom_range(0, step_max);
					send_item(MODE_REFILL, $urandom, clock_ms);
					repeat ($urandom_range(28, 36)) send_item(MODE_BIT, $urandom, $urandom);
				end
			endcase
		end
		idle_on = 1'b0;
		drain();
	endtask

	// Phases under different settings; each register write waits for the block to be idle.
	task automatic test_random_traffic();
		write_reg(REG_WORDS_IN_USE, 32'h0000_0040);
		write_reg(REG_SAMPLE_PERIOD, 32'd1000);
		run_traffic(320, 1'b1, 300);
		write_reg(REG_WORDS_IN_USE, 32'h0000_0001);
		write_reg(REG_SAMPLE_PERIOD, 32'h0000_0000);
		run_traffic(280, 1'b1, 3);
		write_reg(REG_WORDS_IN_USE, 32'hFFFF_FF82);
		write_reg(REG_SAMPLE_PERIOD, 32'd50);
		write_reg(REG_SPARE_A, $urandom);
		write_reg(REG_SPARE_B, $urandom);
		run_traffic(280, 1'b1, 40);
		write_reg(REG_WORDS_IN_USE, 32'd33);
		write_reg(REG_SAMPLE_PERIOD, 32'hFFFF_FFFF);
		run_traffic(300, 1'b1, 100000);
		write_reg(REG_WORDS_IN_USE, 32'h0000_007F);
		write_reg(REG_SAMPLE_PERIOD, 32'd1);
		run_traffic(280, 1'b1, 2);
		// The closing phase runs with neither side idling.
		write_reg(REG_WORDS_IN_USE, 32'd5);
		write_reg(REG_SAMPLE_PERIOD, 32'd200);
		run_traffic(280, 1'b0, 120);
	endtask

	initial begin
		in_valid   = 1'b0;
		in_data    = '0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_WORDS_IN_USE;
		cfg_data   = '0;
		idle_on    = 1'b0;
		fail_count = 0;
		items_sent = 0;
		clock_ms   = $urandom;
		model_reset();
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_shifter();
		test_ring_fill();
		test_capacity_edges();
		test_random_traffic();

		drain();
		repeat (2 * RESULT_LATENCY) @(posedge clk);
		if (fail_count == 0 && pending_status.size() == 0) begin
			$display("word_ring_bit_unpacker verification clean");
		end else begin
			$display("word_ring_bit_unpacker verification failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("word_ring_bit_unpacker verification failed");
		$finish;
	end

endmodule
